// ===== design/rgst_pkg.sv =====
// ----------------------------------------------------------------------------
// rgst_pkg
// Shared types and constants for the reference-counted glyph slot table:
// operation and status codes, plus the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rgst_pkg;

  // field widths
  localparam int KEY_W       = 21;
  localparam int COUNT_W     = 16;
  localparam int ENTRY_W     = KEY_W + COUNT_W;
  localparam int OP_W        = 2;
  localparam int SLOT_W      = 8;
  localparam int IDX_OUT_W   = 6;
  localparam int COORD_W     = 11;
  localparam int STATUS_W    = 3;

  // saturation point of a use count
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // fixed-point shift for the divide-by-columns reciprocal
  localparam int RECIP_SHIFT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER    = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 3'd0,
    ST_EXISTING = 3'd1,
    ST_NO_FONT  = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_SLOT = 3'd4,
    ST_UNUSED   = 3'd5
  } status_t;

  // source of the reported slot index
  typedef enum logic [1:0] {
    IDX_ZERO = 2'd0,
    IDX_SLOT = 2'd1,
    IDX_CMP  = 2'd2,
    IDX_FREE = 2'd3
  } idx_sel_t;

  // kind of table write
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_HIT   = 2'd1,
    WR_ALLOC = 2'd2,
    WR_DEC   = 2'd3
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     scan_step;
    logic     scan_track;
    wr_sel_t  wr_sel;
    logic     clear_all;
    logic     emit;
    status_t  status;
    idx_sel_t idx_sel;
    logic     coord_en;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic font_ok;
    logic slot_bad;
    logic slot_used;
    logic hit;
    logic last;
    logic free_any;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/rgst_ram.sv =====
// ----------------------------------------------------------------------------
// rgst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/rgst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgst_ctrl
// Controller for the glyph slot table: decodes each operation, runs the
// register scan over the slot memory and sequences writes and results.
// ----------------------------------------------------------------------------
`default_nettype none

module rgst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rgst_pkg::dp_stat_t stat,
  output rgst_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  import rgst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_REL_WR,
    S_Q_COL,
    S_Q_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (stat.op)
          OP_REGISTER: begin
            if (!stat.font_ok) begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_NO_FONT;
              cmd.idx_sel = IDX_ZERO;
              state_next  = S_IDLE;
            end else begin
              cmd.scan_step = 1'b1;
              state_next    = S_SCAN;
            end
          end
          OP_RELEASE: begin
            if (stat.slot_bad) begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_BAD_SLOT;
              cmd.idx_sel = IDX_SLOT;
              state_next  = S_IDLE;
            end else begin
              state_next = S_REL_WR;
            end
          end
          OP_RELEASE_ALL: begin
            cmd.clear_all = 1'b1;
            cmd.emit      = 1'b1;
            cmd.status    = ST_NEW;
            cmd.idx_sel   = IDX_ZERO;
            state_next    = S_IDLE;
          end
          OP_QUERY: begin
            if (stat.slot_bad) begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_BAD_SLOT;
              cmd.idx_sel = IDX_SLOT;
              state_next  = S_IDLE;
            end else if (!stat.slot_used) begin
              cmd.emit    = 1'b1;
              cmd.status  = ST_UNUSED;
              cmd.idx_sel = IDX_SLOT;
              state_next  = S_IDLE;
            end else begin
              state_next = S_Q_COL;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // one slot compared per cycle; a key hit ends the scan early
      S_SCAN: begin
        if (stat.hit) begin
          cmd.wr_sel  = WR_HIT;
          cmd.emit    = 1'b1;
          cmd.status  = ST_EXISTING;
          cmd.idx_sel = IDX_CMP;
          state_next  = S_IDLE;
        end else if (stat.last) begin
          cmd.emit = 1'b1;
          if (stat.free_any) begin
            cmd.wr_sel  = WR_ALLOC;
            cmd.status  = ST_NEW;
            cmd.idx_sel = IDX_FREE;
          end else begin
            cmd.status  = ST_FULL;
            cmd.idx_sel = IDX_ZERO;
          end
          state_next = S_IDLE;
        end else begin
          cmd.scan_step  = 1'b1;
          cmd.scan_track = 1'b1;
        end
      end

      // count read back; the decremented value is written if the slot is in use
      S_REL_WR: begin
        if (stat.slot_used) begin
          cmd.wr_sel = WR_DEC;
        end
        cmd.emit    = 1'b1;
        cmd.status  = ST_NEW;
        cmd.idx_sel = IDX_SLOT;
        state_next  = S_IDLE;
      end

      S_Q_COL: begin
        state_next = S_Q_OUT;
      end

      S_Q_OUT: begin
        cmd.emit     = 1'b1;
        cmd.status   = ST_NEW;
        cmd.idx_sel  = IDX_SLOT;
        cmd.coord_en = 1'b1;
        state_next   = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== design/rgst_dp.sv =====
// ----------------------------------------------------------------------------
// rgst_dp
// Datapath for the glyph slot table: captured operands, slot memory holding
// key and count, per-slot in-use bits, scan pointers, atlas position math
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgst_dp #(
  parameter int SLOTS      = 64,
  parameter int COLUMNS    = 8,
  parameter int GLYPH_SIZE = 90
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_data,
  input  wire logic [rgst_pkg::OP_W-1:0]          operation,
  input  wire logic [rgst_pkg::KEY_W-1:0]         code_point,
  input  wire logic [rgst_pkg::SLOT_W-1:0]        slot,
  input  wire rgst_pkg::dp_cmd_t                  cmd,
  output rgst_pkg::dp_stat_t                      stat,
  output logic                                    done,
  output logic      [rgst_pkg::STATUS_W-1:0]      status,
  output logic      [rgst_pkg::IDX_OUT_W-1:0]     slot_index,
  output logic      [rgst_pkg::COORD_W-1:0]       atlas_x,
  output logic      [rgst_pkg::COORD_W-1:0]       atlas_y
);

  import rgst_pkg::*;

  localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RECIP  = ((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS;
  localparam int PROD_W = SLOT_W + RECIP_SHIFT + 1;
  localparam int MUL_W  = 16;

  // captured operands and config
  logic              font_loaded;
  op_t               op_r;
  logic [KEY_W-1:0]  code_r;
  logic [SLOT_W-1:0] slot_r;

  // scan pointers
  logic [IW-1:0]     scan_addr;
  logic [IW-1:0]     cmp_idx;
  logic              free_found;
  logic [IW-1:0]     free_idx;

  // slot in use (count nonzero)
  logic [SLOTS-1:0]  valid;

  // atlas position pipeline
  logic [PROD_W-1:0] div_prod;
  logic [MUL_W-1:0]  row_mul;
  logic [SLOT_W-1:0] row_r;
  logic [SLOT_W-1:0] col_r;
  logic [MUL_W-1:0]  x_prod;
  logic [MUL_W-1:0]  y_prod;

  // memory ports
  logic [IW-1:0]      slot_idx;
  logic [IW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] count_inc;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IW-1:0]      free_cand;
  logic [SLOT_W-1:0]  idx_wide;

  assign slot_idx  = slot_r[IW-1:0];
  assign rd_addr   = (op_r == OP_REGISTER) ? scan_addr : slot_idx;
  assign rd_key    = rd_data[ENTRY_W-1:COUNT_W];
  assign rd_count  = rd_data[COUNT_W-1:0];
  assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
  assign free_cand = free_found ? free_idx : cmp_idx;

  // status toward the controller
  always_comb begin
    stat.op        = op_r;
    stat.font_ok   = font_loaded;
    stat.slot_bad  = ({1'b0, slot_r} >= (SLOT_W + 1)'(SLOTS));
    stat.slot_used = !stat.slot_bad && valid[slot_idx];
    stat.hit       = valid[cmp_idx] && (rd_key == code_r);
    stat.last      = (cmp_idx == IW'(SLOTS - 1));
    stat.free_any  = free_found || !valid[cmp_idx];
  end

  // table write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_data = {code_r, count_inc};
    case (cmd.wr_sel)
      WR_HIT: begin
        wr_en   = 1'b1;
        wr_addr = cmp_idx;
        wr_data = {code_r, count_inc};
      end
      WR_ALLOC: begin
        wr_en   = 1'b1;
        wr_addr = free_cand;
        wr_data = {code_r, COUNT_W'(1)};
      end
      WR_DEC: begin
        wr_en   = 1'b1;
        wr_addr = slot_idx;
        wr_data = {rd_key, rd_count - COUNT_W'(1)};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  rgst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // font present flag
  always_ff @(posedge clk) begin
    if (rst) begin
      font_loaded <= 1'b0;
    end else if (cfg_we) begin
      font_loaded <= cfg_data;
    end
  end

  // operand capture on an accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(operation);
      code_r <= code_point;
      slot_r <= slot;
    end
  end

  // scan pointers; the compare index is the registered read address of the step before
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      cmp_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else if (cmd.capture) begin
      scan_addr  <= '0;
      free_found <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + IW'(1);
      cmp_idx   <= scan_addr;
      if (cmd.scan_track && !free_found && !valid[cmp_idx]) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  // in-use bits
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= '0;
    end else if (cmd.wr_sel == WR_ALLOC) begin
      valid[free_cand] <= 1'b1;
    end else if (cmd.wr_sel == WR_DEC && rd_count == COUNT_W'(1)) begin
      valid[slot_idx] <= 1'b0;
    end
  end

  // row by reciprocal multiply, then column by subtraction
  assign div_prod = PROD_W'(slot_r) * PROD_W'(RECIP);
  assign row_mul  = MUL_W'(row_r) * MUL_W'(COLUMNS);
  assign x_prod   = MUL_W'(col_r) * MUL_W'(GLYPH_SIZE);
  assign y_prod   = MUL_W'(row_r) * MUL_W'(GLYPH_SIZE);

  always_ff @(posedge clk) begin
    row_r <= div_prod[RECIP_SHIFT +: SLOT_W];
    col_r <= SLOT_W'(MUL_W'(slot_r) - row_mul);
  end

  // reported index source
  always_comb begin
    case (cmd.idx_sel)
      IDX_SLOT: idx_wide = slot_r;
      IDX_CMP:  idx_wide = SLOT_W'(cmp_idx);
      IDX_FREE: idx_wide = SLOT_W'(free_cand);
      default:  idx_wide = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      status     <= cmd.status;
      slot_index <= idx_wide[IDX_OUT_W-1:0];
      atlas_x    <= cmd.coord_en ? x_prod[COORD_W-1:0] : '0;
      atlas_y    <= cmd.coord_en ? y_prod[COORD_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/refcounted_glyph_slot_table_top.sv =====
// Release all, no-font register, out-of-range slot and query of an unused
// slot end in dispatch; release reads the count, then writes it decremented
// if in use; query steps through column and output states; register scans to
// a key hit or the last slot. The register scan reads the slot memory one
// entry per cycle; the next beat is accepted in the cycle the done strobe is
// shown (busy low). Synchronous active-high rst clears the controller, the
// font flag, the in-use bits and the done strobe; no clearing pass is needed.
// ----------------------------------------------------------------------------
// refcounted_glyph_slot_table_top
// Reference-counted glyph atlas slot table: register, release, release-all
// and atlas position query, one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_glyph_slot_table_top #(
  parameter int SLOTS      = 64,
  parameter int COLUMNS    = 8,
  parameter int GLYPH_SIZE = 90
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [rgst_pkg::OP_W-1:0]         operation,
  input  wire logic [rgst_pkg::KEY_W-1:0]        code_point,
  input  wire logic [rgst_pkg::SLOT_W-1:0]       slot,
  output logic                                   done,
  output logic      [rgst_pkg::STATUS_W-1:0]     status,
  output logic      [rgst_pkg::IDX_OUT_W-1:0]    slot_index,
  output logic      [rgst_pkg::COORD_W-1:0]      atlas_x,
  output logic      [rgst_pkg::COORD_W-1:0]      atlas_y
);

  import rgst_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  rgst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table storage and arithmetic
  rgst_dp #(
    .SLOTS      (SLOTS),
    .COLUMNS    (COLUMNS),
    .GLYPH_SIZE (GLYPH_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .code_point (code_point),
    .slot       (slot),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .slot_index (slot_index),
    .atlas_x    (atlas_x),
    .atlas_y    (atlas_y)
  );

endmodule

`default_nettype wire

// ===== design/rgst_props.sv =====
// ----------------------------------------------------------------------------
// rgst_props
// Port-level properties of the glyph slot table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgst_props (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic [rgst_pkg::STATUS_W-1:0]  status,
  input wire logic [rgst_pkg::IDX_OUT_W-1:0] slot_index,
  input wire logic [rgst_pkg::COORD_W-1:0]   atlas_x,
  input wire logic [rgst_pkg::COORD_W-1:0]   atlas_y
);

  import rgst_pkg::*;

  // an accepted beat always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // the block goes idle only when it delivers a result
  a_idle_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  // a result is never shown while a command is still at work
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // only a successful query carries coordinates; checked here for results other than ST_NEW
  a_coord_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_NEW) |-> (atlas_x == '0 && atlas_y == '0))
    else $error("coordinates on a non-query result");

  // failed registrations report slot zero
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NO_FONT || status == ST_FULL)) |-> (slot_index == '0))
    else $error("failed register reported a slot");

endmodule

bind refcounted_glyph_slot_table_top rgst_props u_props (.*);

`default_nettype wire
